/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the address generator modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define PKVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PKVC_ASSERT_SAME(label, ante, cons, msg) \
  `PKVC_ASSERT(label, (ante) |-> (cons), msg)

// Antecedent implies consequent in the following cycle.
`define PKVC_ASSERT_NEXT(label, ante, cons, msg) \
  `PKVC_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* hdl/pkvc_pkg.sv */
// ---------------------------------------------------------------------------
// pkvc_pkg
// Types and fixed constants of the paged KV-cache tile address generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pkvc_pkg;

  // Field widths of the item and result words.
  localparam int WORD_W    = 32;
  localparam int BATCH_W   = 5;
  localparam int SLOT_W    = 6;
  localparam int PHYS_W    = 20;
  localparam int HEAD_W    = 6;
  localparam int CFG_IDX_W = 3;

  // Widest narrow operand of the shared multiplier (block_tiles).
  localparam int MUL_B_W = 11;

  // Quotient bits retired per divider cycle.
  localparam int DIV_RADIX_BITS = 2;

  // Heads per request are capped at this figure.
  localparam int RESULT_LIMIT = 64;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  // Address modes.
  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_CONTIG = 2'd1;
  localparam logic [1:0] MODE_PAGED  = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDRESS_MODE       = 3'd0,
    CFG_WIDTH_TILES        = 3'd1,
    CFG_HEAD_COUNT         = 3'd2,
    CFG_SEQ_TILES          = 3'd3,
    CFG_BLOCK_ROWS         = 3'd4,
    CFG_BLOCK_TILES        = 3'd5,
    CFG_POSITION_MODULO    = 3'd6,
    CFG_BATCH_STRIDE_TILES = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]        address_mode;
    logic [8:0]        width_tiles;
    logic [6:0]        head_count;
    logic [15:0]       seq_tiles;
    logic [15:0]       block_rows;
    logic [10:0]       block_tiles;
    logic [WORD_W-1:0] position_modulo;
    logic [WORD_W-1:0] batch_stride_tiles;
  } cfg_t;

  // Class of a queued word, decided by the front end.
  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_SKIP   = 3'd1,
    OP_DIRECT = 3'd2,
    OP_CONTIG = 3'd3,
    OP_PAGED  = 3'd4,
    OP_FAULT  = 3'd5
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BATCH_W-1:0] batch;
    logic [SLOT_W-1:0]  slot;
    logic [PHYS_W-1:0]  phys;
    logic [WORD_W-1:0]  value;
  } entry_t;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* hdl/pkvc_if.sv */
// ---------------------------------------------------------------------------
// pkvc_if
// Valid/ready channels for input words and result words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pkvc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [pkvc_pkg::BATCH_W-1:0] batch_index;
  logic [pkvc_pkg::SLOT_W-1:0]  block_slot;
  logic [pkvc_pkg::PHYS_W-1:0]  physical_block;
  logic [pkvc_pkg::WORD_W-1:0]  position;
  logic [pkvc_pkg::WORD_W-1:0]  start_tile;

  modport source (
    output valid, action, batch_index, block_slot, physical_block, position, start_tile,
    input  ready
  );
  modport sink (
    input  valid, action, batch_index, block_slot, physical_block, position, start_tile,
    output ready
  );
endinterface

interface pkvc_out_if;
  logic                        valid;
  logic                        ready;
  logic [pkvc_pkg::HEAD_W-1:0] head_index;
  logic [pkvc_pkg::WORD_W-1:0] first_tile;
  logic                        skipped;
  logic                        block_fault;
  logic                        last;

  modport source (
    output valid, head_index, first_tile, skipped, block_fault, last,
    input  ready
  );
  modport sink (
    input  valid, head_index, first_tile, skipped, block_fault, last,
    output ready
  );
endinterface

/* hdl/pkvc_ram.sv */
// ---------------------------------------------------------------------------
// pkvc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkvc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/pkvc_queue.sv */
// ---------------------------------------------------------------------------
// pkvc_queue
// Short FIFO of classified words between the front end and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pkvc_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pkvc_pkg::entry_t push_data,
  input  logic             pop,
  output pkvc_pkg::entry_t head,
  output logic             full,
  output logic             empty
);
  import pkvc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage carries no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `PKVC_ASSERT_SAME(a_pop_not_empty, pop, !empty, "queue popped while empty")

endmodule

/* hdl/pkvc_divider.sv */
// ---------------------------------------------------------------------------
// pkvc_divider
// Iterative unsigned 32-bit divider, restoring, two quotient bits a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pkvc_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  pkvc_pkg::div_req_t req,
  output pkvc_pkg::div_rsp_t rsp
);
  import pkvc_pkg::*;

  localparam int STEPS  = WORD_W / DIV_RADIX_BITS;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [WORD_W-1:0] dvs_r;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;

  // Retire the next quotient bits; a zero divisor yields all ones and
  // leaves the dividend as the remainder.
  always_comb begin
    logic [WORD_W:0] trial;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial   = {rem_nxt, quo_nxt[WORD_W-1]};
      quo_nxt = {quo_nxt[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial      = trial - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[WORD_W-1:0];
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs_r <= req.divisor;
      quo_r <= req.dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  `PKVC_ASSERT_NEXT(a_start_busy, req.start, busy_r, "divider not busy after start")

endmodule

/* hdl/pkvc_front.sv */
// ---------------------------------------------------------------------------
// pkvc_front
// Accepts input words, classifies them and drops those without effect.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkvc_front #(
  parameter int MAX_BATCH               = 32,
  parameter int MAX_BLOCKS_PER_SEQUENCE = 64
) (
  pkvc_in_if.sink          in_ch,
  input  pkvc_pkg::cfg_t   cfg,
  input  logic             q_full,
  output logic             push,
  output pkvc_pkg::entry_t entry
);
  import pkvc_pkg::*;

  logic batch_ok;
  logic slot_ok;
  logic keep;

  assign in_ch.ready = !q_full;

  assign batch_ok = (WORD_W'(in_ch.batch_index) < WORD_W'(MAX_BATCH));
  assign slot_ok  = (WORD_W'(in_ch.block_slot) < WORD_W'(MAX_BLOCKS_PER_SEQUENCE));

  // Classify the word.
  always_comb begin
    entry.batch = in_ch.batch_index;
    entry.slot  = in_ch.block_slot;
    entry.phys  = in_ch.physical_block;
    entry.value = in_ch.position;
    keep        = 1'b1;
    if (!in_ch.action) begin
      // Table writes outside the table are ignored.
      entry.op = OP_WRITE;
      keep     = batch_ok && slot_ok;
    end else begin
      // A request with no heads has no results and no side effects.
      keep = (cfg.head_count != '0);
      if (in_ch.position == ALL_ONES) begin
        entry.op = OP_SKIP;
      end else if (cfg.address_mode == MODE_CONTIG) begin
        entry.op = OP_CONTIG;
      end else if (cfg.address_mode == MODE_PAGED) begin
        entry.op = batch_ok ? OP_PAGED : OP_FAULT;
      end else begin
        entry.op    = OP_DIRECT;
        entry.value = in_ch.start_tile;
      end
    end
  end

  assign push = in_ch.valid && !q_full && keep;

endmodule

/* hdl/pkvc_back.sv */
// ---------------------------------------------------------------------------
// pkvc_back
// Executes queued words: page-table writes, position divides, page lookup,
// base tile arithmetic and the per-head result run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pkvc_back #(
  parameter int MAX_BATCH               = 32,
  parameter int MAX_BLOCKS_PER_SEQUENCE = 64,
  parameter int TILE_ROWS               = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pkvc_pkg::cfg_t   cfg,
  input  pkvc_pkg::entry_t head,
  input  logic             q_empty,
  output logic             pop,
  pkvc_out_if.source       out_ch
);
  import pkvc_pkg::*;

  localparam int DEPTH = MAX_BATCH * MAX_BLOCKS_PER_SEQUENCE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Division by TILE_ROWS as a reciprocal multiplication:
  // q = (x * RCP_FULL) >> (32 + RCP_SH), exact for every 32-bit x.
  localparam int                  RCP_SH   = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 0;
  localparam logic [2*WORD_W-1:0] RCP_NUM  = (2*WORD_W)'(1) << (WORD_W + RCP_SH);
  localparam logic [2*WORD_W-1:0] RCP_FULL = (RCP_NUM + (2*WORD_W)'(TILE_ROWS)
                                             - (2*WORD_W)'(1)) / (2*WORD_W)'(TILE_ROWS);
  localparam logic [WORD_W-1:0]   RCP_LO   = RCP_FULL[WORD_W-1:0];
  localparam logic                RCP_HI   = RCP_FULL[WORD_W];

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_W_MOD = 11'b000_0000_0010,
    S_W_DIV = 11'b000_0000_0100,
    S_RCP1  = 11'b000_0000_1000,
    S_RCP2  = 11'b000_0001_0000,
    S_M1    = 11'b000_0010_0000,
    S_M2    = 11'b000_0100_0000,
    S_M3    = 11'b000_1000_0000,
    S_M4    = 11'b001_0000_0000,
    S_M5    = 11'b010_0000_0000,
    S_EMIT  = 11'b100_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [BATCH_W-1:0] batch_r, batch_nxt;
  logic               skip_r, skip_nxt;
  logic               fault_r, fault_nxt;
  logic [WORD_W-1:0]  acc_r, acc_nxt;
  logic [WORD_W-1:0]  part_r, part_nxt;
  logic [WORD_W-1:0]  q_r, q_nxt;
  logic [WORD_W-1:0]  stride_r, stride_nxt;
  logic [WORD_W-1:0]  tile_r, tile_nxt;
  logic [HEAD_W-1:0]  h_r, h_nxt;
  logic [HEAD_W-1:0]  h_last_r, h_last_nxt;

  logic [2*WORD_W-1:0] rcp_prod_r, rcp_prod_nxt;
  logic [2*WORD_W:0]   rcp_sum;
  logic [2*WORD_W:0]   rcp_quo;

  logic               out_valid_r, out_valid_nxt;
  logic [HEAD_W-1:0]  out_head_r;
  logic [WORD_W-1:0]  out_tile_r;
  logic               out_skip_r;
  logic               out_fault_r;
  logic               out_last_r;
  logic               emit_load;
  logic               emit_last;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [PHYS_W-1:0]  ram_rdata;
  logic [WORD_W-1:0]  wr_addr_full;
  logic [WORD_W-1:0]  rd_addr_full;

  logic [WORD_W-1:0]          mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [WORD_W+MUL_B_W-1:0]  mul_full;
  logic [WORD_W-1:0]          mul_p;
  logic [6:0]                 heads;
  logic                       out_free;

  // Page table.
  pkvc_ram #(
    .WIDTH (PHYS_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (head.phys),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared divider for the window wrap and the block split.
  pkvc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Table addresses: batch-major, one row of slots per batch.
  assign wr_addr_full = WORD_W'(head.batch) * WORD_W'(MAX_BLOCKS_PER_SEQUENCE)
                      + WORD_W'(head.slot);
  assign rd_addr_full = WORD_W'(batch_r) * WORD_W'(MAX_BLOCKS_PER_SEQUENCE)
                      + div_rsp.quotient;
  assign ram_waddr    = wr_addr_full[AW-1:0];
  assign ram_raddr    = rd_addr_full[AW-1:0];

  // Shared multiplier, products wrap at 32 bits.
  assign mul_full = {{MUL_B_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};
  assign mul_p    = mul_full[WORD_W-1:0];

  // Second half of the row split: add the top reciprocal bit and shift.
  assign rcp_sum = {1'b0, rcp_prod_r}
                 + (RCP_HI ? {1'b0, q_r, {WORD_W{1'b0}}} : {(2*WORD_W+1){1'b0}});
  assign rcp_quo = rcp_sum >> (WORD_W + RCP_SH);

  assign heads    = (cfg.head_count > 7'(RESULT_LIMIT)) ? 7'(RESULT_LIMIT) : cfg.head_count;
  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer.
  always_comb begin
    logic [6:0] heads_m1;
    state_nxt    = state_r;
    op_nxt       = op_r;
    batch_nxt    = batch_r;
    skip_nxt     = skip_r;
    fault_nxt    = fault_r;
    acc_nxt      = acc_r;
    part_nxt     = part_r;
    q_nxt        = q_r;
    stride_nxt   = stride_r;
    tile_nxt     = tile_r;
    h_nxt        = h_r;
    h_last_nxt   = h_last_r;
    rcp_prod_nxt = rcp_prod_r;
    pop          = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    div_req      = '0;
    mul_a        = '0;
    mul_b        = '0;
    emit_load    = 1'b0;
    emit_last    = 1'b0;
    heads_m1     = heads - 7'd1;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          op_nxt    = head.op;
          batch_nxt = head.batch;
          skip_nxt  = 1'b0;
          fault_nxt = 1'b0;
          acc_nxt   = '0;
          part_nxt  = '0;
          case (head.op)
            OP_WRITE: begin
              ram_we = 1'b1;
            end
            OP_SKIP: begin
              skip_nxt  = 1'b1;
              state_nxt = S_M5;
            end
            OP_FAULT: begin
              fault_nxt = 1'b1;
              state_nxt = S_M5;
            end
            OP_CONTIG: begin
              if (cfg.position_modulo != '0) begin
                div_req.start    = 1'b1;
                div_req.dividend = head.value;
                div_req.divisor  = cfg.position_modulo;
                state_nxt        = S_W_MOD;
              end else begin
                q_nxt     = head.value;
                state_nxt = S_RCP1;
              end
            end
            OP_PAGED: begin
              div_req.start    = 1'b1;
              div_req.dividend = head.value;
              if (cfg.position_modulo != '0) begin
                div_req.divisor = cfg.position_modulo;
                state_nxt       = S_W_MOD;
              end else begin
                div_req.divisor = WORD_W'(cfg.block_rows);
                state_nxt       = S_W_DIV;
              end
            end
            default: begin
              // Direct start tile.
              acc_nxt   = head.value;
              state_nxt = S_M5;
            end
          endcase
        end
      end

      S_W_MOD: begin
        if (div_rsp.done) begin
          if (op_r == OP_CONTIG) begin
            q_nxt     = div_rsp.remainder;
            state_nxt = S_RCP1;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.remainder;
            div_req.divisor  = WORD_W'(cfg.block_rows);
            state_nxt        = S_W_DIV;
          end
        end
      end

      S_W_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient >= WORD_W'(MAX_BLOCKS_PER_SEQUENCE)) begin
            // Virtual block beyond the table.
            fault_nxt = 1'b1;
            state_nxt = S_M5;
          end else begin
            ram_re    = 1'b1;
            q_nxt     = div_rsp.remainder;
            state_nxt = S_RCP1;
          end
        end
      end

      S_RCP1: begin
        // Low part of the reciprocal product.
        rcp_prod_nxt = {{WORD_W{1'b0}}, q_r} * {{WORD_W{1'b0}}, RCP_LO};
        state_nxt    = S_RCP2;
      end

      S_RCP2: begin
        q_nxt     = rcp_quo[WORD_W-1:0];
        state_nxt = S_M1;
      end

      S_M1: begin
        if (op_r == OP_CONTIG) begin
          mul_a     = cfg.batch_stride_tiles;
          mul_b     = MUL_B_W'(batch_r);
          state_nxt = S_M4;
        end else begin
          mul_a     = WORD_W'(ram_rdata);
          mul_b     = MUL_B_W'(cfg.head_count);
          state_nxt = S_M2;
        end
        acc_nxt = mul_p;
      end

      S_M2: begin
        mul_a     = acc_r;
        mul_b     = cfg.block_tiles;
        acc_nxt   = mul_p;
        state_nxt = S_M3;
      end

      S_M3: begin
        mul_a     = acc_r;
        mul_b     = MUL_B_W'(cfg.width_tiles);
        acc_nxt   = mul_p;
        state_nxt = S_M4;
      end

      S_M4: begin
        mul_a     = q_r;
        mul_b     = MUL_B_W'(cfg.width_tiles);
        part_nxt  = mul_p;
        state_nxt = S_M5;
      end

      S_M5: begin
        // Head stride and base tile of head zero.
        mul_a      = WORD_W'(cfg.seq_tiles);
        mul_b      = MUL_B_W'(cfg.width_tiles);
        stride_nxt = mul_p;
        tile_nxt   = acc_r + part_r;
        h_nxt      = '0;
        h_last_nxt = heads_m1[HEAD_W-1:0];
        state_nxt  = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          emit_load = 1'b1;
          emit_last = (h_r == h_last_r);
          tile_nxt  = tile_r + stride_r;
          h_nxt     = h_r + HEAD_W'(1);
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    batch_r    <= batch_nxt;
    skip_r     <= skip_nxt;
    fault_r    <= fault_nxt;
    acc_r      <= acc_nxt;
    part_r     <= part_nxt;
    q_r        <= q_nxt;
    stride_r   <= stride_nxt;
    tile_r     <= tile_nxt;
    h_r        <= h_nxt;
    h_last_r   <= h_last_nxt;
    rcp_prod_r <= rcp_prod_nxt;
  end

  // Result word; skipped and faulted runs carry tile zero.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_head_r  <= h_r;
      out_tile_r  <= (skip_r || fault_r) ? '0 : tile_r;
      out_skip_r  <= skip_r;
      out_fault_r <= fault_r;
      out_last_r  <= emit_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.head_index  = out_head_r;
  assign out_ch.first_tile  = out_tile_r;
  assign out_ch.skipped     = out_skip_r;
  assign out_ch.block_fault = out_fault_r;
  assign out_ch.last        = out_last_r;

  `PKVC_ASSERT_SAME(a_div_done_waiting, div_rsp.done,
    state_r == S_W_MOD || state_r == S_W_DIV,
    "divider finished outside a wait state")
  `PKVC_ASSERT_NEXT(a_last_to_idle, emit_load && emit_last, state_r == S_IDLE,
    "sequencer not idle after the final head")
  `PKVC_ASSERT_SAME(a_no_tile_on_flag,
    out_ch.valid && (out_ch.skipped || out_ch.block_fault), out_ch.first_tile == '0,
    "flagged result carries a tile id")

endmodule

/* hdl/paged_kv_cache_tile_address_generator.sv */
// Paged KV-cache tile address generator. A table-write word (action 0) stores a
// physical block number in the page table when the back end takes it from the
// queue; the page table is not cleared after reset, so every entry that a paged
// request looks up must have been written first. A request word (action 1)
// yields min(head_count, 64) results, one per cycle while the sink is ready.
// After the back end takes a request from the queue, it goes to S_M5 and then
// S_EMIT, which loads the result register. Skipped, direct and batch-faulted
// requests go there at once; contiguous ones first pass S_RCP1, S_RCP2, S_M1
// and S_M4, paged ones S_W_DIV, S_RCP1, S_RCP2 and S_M1 through S_M4, and
// a paged request whose block lies past the table goes from S_W_DIV to S_M5.
// A nonzero position_modulo adds S_W_MOD to any contiguous or paged request.
// The shared radix-4 divider retires two quotient bits a cycle; the division
// by TILE_ROWS is a reciprocal multiplication in S_RCP1 and S_RCP2. A two-word
// queue parts the input side from the sequencer, and a result register parts
// it from the output, so words are taken while results drain.
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// paged_kv_cache_tile_address_generator
// Top level: configuration registers, front end, queue and back end.
// ---------------------------------------------------------------------------
module paged_kv_cache_tile_address_generator #(
  parameter int MAX_BATCH               = 32,
  parameter int MAX_BLOCKS_PER_SEQUENCE = 64,
  parameter int TILE_ROWS               = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pkvc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pkvc_pkg::WORD_W-1:0]      cfg_wdata,
  pkvc_in_if.sink                          in_ch,
  pkvc_out_if.source                       out_ch
);
  import pkvc_pkg::*;

  cfg_t   cfg_r;
  entry_t push_entry;
  entry_t q_head;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address_mode       <= MODE_DIRECT;
      cfg_r.width_tiles        <= 9'd1;
      cfg_r.head_count         <= 7'd1;
      cfg_r.seq_tiles          <= 16'd1;
      cfg_r.block_rows         <= 16'd32;
      cfg_r.block_tiles        <= 11'd1;
      cfg_r.position_modulo    <= '0;
      cfg_r.batch_stride_tiles <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ADDRESS_MODE:       cfg_r.address_mode       <= cfg_wdata[1:0];
        CFG_WIDTH_TILES:        cfg_r.width_tiles        <= cfg_wdata[8:0];
        CFG_HEAD_COUNT:         cfg_r.head_count         <= cfg_wdata[6:0];
        CFG_SEQ_TILES:          cfg_r.seq_tiles          <= cfg_wdata[15:0];
        CFG_BLOCK_ROWS:         cfg_r.block_rows         <= cfg_wdata[15:0];
        CFG_BLOCK_TILES:        cfg_r.block_tiles        <= cfg_wdata[10:0];
        CFG_POSITION_MODULO:    cfg_r.position_modulo    <= cfg_wdata;
        CFG_BATCH_STRIDE_TILES: cfg_r.batch_stride_tiles <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Front end: accept and classify.
  pkvc_front #(
    .MAX_BATCH               (MAX_BATCH),
    .MAX_BLOCKS_PER_SEQUENCE (MAX_BLOCKS_PER_SEQUENCE)
  ) u_front (
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .push   (push),
    .entry  (push_entry)
  );

  // Queue between the two halves.
  pkvc_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: table writes, arithmetic and result run.
  pkvc_back #(
    .MAX_BATCH               (MAX_BATCH),
    .MAX_BLOCKS_PER_SEQUENCE (MAX_BLOCKS_PER_SEQUENCE),
    .TILE_ROWS               (TILE_ROWS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .head    (q_head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* test/pkvc_tile_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pkvc_tile_checker
// Watches the configuration port and both channels of the tile address
// generator, keeps its own copy of the settings and the page table, predicts
// the result words of every accepted request and compares each result word
// with the oldest prediction, field by field.
// ---------------------------------------------------------------------------

module pkvc_tile_checker #(
  parameter int MAX_BATCH               = 32,
  parameter int MAX_BLOCKS_PER_SEQUENCE = 64,
  parameter int TILE_ROWS               = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pkvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pkvc_pkg::WORD_W-1:0]    cfg_wdata,
  pkvc_in_if                             in_mon,
  pkvc_out_if                            out_mon,
  output int                             fail_count,
  output int                             pending_count
);
  import pkvc_pkg::*;

  localparam int TABLE_DEPTH = MAX_BATCH * MAX_BLOCKS_PER_SEQUENCE;

  typedef struct packed {
    logic [HEAD_W-1:0] head_index;
    logic [WORD_W-1:0] first_tile;
    logic              skipped;
    logic              block_fault;
    logic              last;
  } tile_result_t;

  tile_result_t      tiles_due [$];
  logic [PHYS_W-1:0] block_map [TABLE_DEPTH];
  cfg_t              regs;
  int                mismatches = 0;

  assign fail_count = mismatches;

  // Works out the base tile of a request and queues one result word per head.
  task automatic queue_tiles(input logic [BATCH_W-1:0] batch,
                             input logic [WORD_W-1:0] position,
                             input logic [WORD_W-1:0] start);
    logic [WORD_W-1:0] pos;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] stride;
    logic [WORD_W-1:0] vblock;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] heads;
    logic [WORD_W-1:0] wt;
    logic [WORD_W-1:0] phys;
    logic              skip;
    logic              fault;
    tile_result_t      r;
    wt     = WORD_W'(regs.width_tiles);
    heads  = (regs.head_count > RESULT_LIMIT) ? WORD_W'(RESULT_LIMIT)
                                              : WORD_W'(regs.head_count);
    stride = wt * WORD_W'(regs.seq_tiles);
    base   = '0;
    skip   = 1'b0;
    fault  = 1'b0;
    if (position == ALL_ONES) begin
      skip = 1'b1;
    end else begin
      pos = (regs.position_modulo != 0) ? position % regs.position_modulo : position;
      if (regs.address_mode == MODE_CONTIG) begin
        base = WORD_W'(batch) * regs.batch_stride_tiles + (pos / TILE_ROWS) * wt;
      end else if (regs.address_mode == MODE_PAGED) begin
        // A zero divisor gives an all-ones quotient, which always faults.
        vblock = (regs.block_rows != 0) ? pos / regs.block_rows : ALL_ONES;
        rem    = (regs.block_rows != 0) ? pos % regs.block_rows : pos;
        if (vblock >= MAX_BLOCKS_PER_SEQUENCE || batch >= MAX_BATCH) begin
          fault = 1'b1;
        end else begin
          phys = WORD_W'(block_map[int'(batch) * MAX_BLOCKS_PER_SEQUENCE + int'(vblock)]);
          // The unsaturated head count scales the physical block.
          base = phys * WORD_W'(regs.head_count) * WORD_W'(regs.block_tiles) * wt
               + (rem / TILE_ROWS) * wt;
        end
      end else begin
        base = start;
      end
    end
    for (int h = 0; h < heads; h++) begin
      r.head_index  = HEAD_W'(h);
      r.first_tile  = (skip || fault) ? '0 : base + WORD_W'(h) * stride;
      r.skipped     = skip;
      r.block_fault = fault;
      r.last        = (h + 1 == heads);
      tiles_due     = {tiles_due, r};
    end
  endtask

  // Result words are checked before the input word of the same edge is
  // predicted, as a word never yields a result at the edge it is taken.
  always @(posedge clk) begin : watch
    tile_result_t want;
    if (!rst_n) begin
      regs.address_mode       = MODE_DIRECT;
      regs.width_tiles        = 9'd1;
      regs.head_count         = 7'd1;
      regs.seq_tiles          = 16'd1;
      regs.block_rows         = 16'd32;
      regs.block_tiles        = 11'd1;
      regs.position_modulo    = '0;
      regs.batch_stride_tiles = '0;
      tiles_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (tiles_due.size() == 0) begin
          $error("result word with no prediction waiting: head_index %0d first_tile %0h",
                 out_mon.head_index, out_mon.first_tile);
          mismatches++;
        end else begin
          want = tiles_due.pop_front();
          if (out_mon.head_index !== want.head_index) begin
            $error("head_index: expected %0d, actual %0d", want.head_index,
                   out_mon.head_index);
            mismatches++;
          end
          if (out_mon.first_tile !== want.first_tile) begin
            $error("first_tile: expected %0h, actual %0h", want.first_tile,
                   out_mon.first_tile);
            mismatches++;
          end
          if (out_mon.skipped !== want.skipped) begin
            $error("skipped: expected %0b, actual %0b", want.skipped, out_mon.skipped);
            mismatches++;
          end
          if (out_mon.block_fault !== want.block_fault) begin
            $error("block_fault: expected %0b, actual %0b", want.block_fault,
                   out_mon.block_fault);
            mismatches++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_mon.last);
            mismatches++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == 1'b0) begin
          // Table writes outside the table are dropped.
          if (in_mon.batch_index < MAX_BATCH && in_mon.block_slot < MAX_BLOCKS_PER_SEQUENCE)
            block_map[int'(in_mon.batch_index) * MAX_BLOCKS_PER_SEQUENCE
                      + int'(in_mon.block_slot)] = in_mon.physical_block;
        end else begin
          queue_tiles(in_mon.batch_index, in_mon.position, in_mon.start_tile);
        end
      end

      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_ADDRESS_MODE:       regs.address_mode       = cfg_wdata[1:0];
          CFG_WIDTH_TILES:        regs.width_tiles        = cfg_wdata[8:0];
          CFG_HEAD_COUNT:         regs.head_count         = cfg_wdata[6:0];
          CFG_SEQ_TILES:          regs.seq_tiles          = cfg_wdata[15:0];
          CFG_BLOCK_ROWS:         regs.block_rows         = cfg_wdata[15:0];
          CFG_BLOCK_TILES:        regs.block_tiles        = cfg_wdata[10:0];
          CFG_POSITION_MODULO:    regs.position_modulo    = cfg_wdata;
          CFG_BATCH_STRIDE_TILES: regs.batch_stride_tiles = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending_count <= tiles_due.size();
  end

endmodule

/* test/tb_paged_kv_cache_tile_address_generator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_paged_kv_cache_tile_address_generator
// Drives table writes and address requests into the tile address generator
// under a series of register settings, directed corner cases first and then
// random phases with changing back-pressure, and reports the verdict of the
// checker that sits beside the block.
// ---------------------------------------------------------------------------

module tb_paged_kv_cache_tile_address_generator;
  import pkvc_pkg::*;

  localparam int MAX_BATCH    = 32;
  localparam int MAX_BLOCKS   = 64;
  localparam int TILE_ROWS    = 32;
  localparam int QUIET_CYCLES = 400;
  localparam int HOLD_CYCLES  = 600;
  localparam int PHASES       = 12;
  localparam int HOLD_PHASE   = 9;

  // Mode code with no name of its own; the block treats it as direct.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;
  logic                 rx_ready = 1'b0;
  logic                 hold_on = 1'b0;
  int                   rx_idle_pct = 0;
  int                   tx_idle_pct = 0;
  int                   chk_fails;
  int                   chk_pending;
  event                 hold_go;
  cfg_t                 cur;
  bit                   page_written [MAX_BATCH * MAX_BLOCKS];

  pkvc_in_if  in_ch ();
  pkvc_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  paged_kv_cache_tile_address_generator #(
    .MAX_BATCH              (MAX_BATCH),
    .MAX_BLOCKS_PER_SEQUENCE(MAX_BLOCKS),
    .TILE_ROWS              (TILE_ROWS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  pkvc_tile_checker #(
    .MAX_BATCH              (MAX_BATCH),
    .MAX_BLOCKS_PER_SEQUENCE(MAX_BLOCKS),
    .TILE_ROWS              (TILE_ROWS)
  ) mon (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (chk_fails),
    .pending_count(chk_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stalls, or a long hold-off while one is running.
  always @(posedge clk) begin
    if (!rst_n || hold_on)
      rx_ready <= 1'b0;
    else
      rx_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Long hold-off of the result side, counted here so the sender keeps going.
  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb_paged_kv_cache_tile_address_generator: errors");
    $finish;
  end

  function automatic cfg_t make_settings(input logic [1:0] mode, input logic [8:0] width,
                                         input logic [6:0] heads, input logic [15:0] seq,
                                         input logic [15:0] rows, input logic [10:0] btiles,
                                         input logic [31:0] modulo,
                                         input logic [31:0] bstride);
    cfg_t s;
    s.address_mode       = mode;
    s.width_tiles        = width;
    s.head_count         = heads;
    s.seq_tiles          = seq;
    s.block_rows         = rows;
    s.block_tiles        = btiles;
    s.position_modulo    = modulo;
    s.batch_stride_tiles = bstride;
    return s;
  endfunction

  task automatic write_reg(input cfg_index_t idx, input logic [WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Waits until every predicted word is out and the block has had time to
  // finish any request that yields no results.
  task automatic drain();
    do begin
      @(posedge clk);
      while (chk_pending != 0) @(posedge clk);
      repeat (QUIET_CYCLES) @(posedge clk);
    end while (chk_pending != 0);
  endtask

  task automatic apply_settings(input cfg_t s);
    in_ch.valid <= 1'b0;
    drain();
    write_reg(CFG_ADDRESS_MODE, WORD_W'(s.address_mode));
    write_reg(CFG_WIDTH_TILES, WORD_W'(s.width_tiles));
    write_reg(CFG_HEAD_COUNT, WORD_W'(s.head_count));
    write_reg(CFG_SEQ_TILES, WORD_W'(s.seq_tiles));
    write_reg(CFG_BLOCK_ROWS, WORD_W'(s.block_rows));
    write_reg(CFG_BLOCK_TILES, WORD_W'(s.block_tiles));
    write_reg(CFG_POSITION_MODULO, s.position_modulo);
    write_reg(CFG_BATCH_STRIDE_TILES, s.batch_stride_tiles);
    cfg_we <= 1'b0;
    cur = s;
  endtask

  // Offers one word, with random idle cycles ahead of it, and returns at the
  // edge that takes it; valid is left high for a following word.
  task automatic send_word(input logic action, input logic [BATCH_W-1:0] batch,
                           input logic [SLOT_W-1:0] slot, input logic [PHYS_W-1:0] phys,
                           input logic [WORD_W-1:0] position,
                           input logic [WORD_W-1:0] start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= action;
    in_ch.batch_index    <= batch;
    in_ch.block_slot     <= slot;
    in_ch.physical_block <= phys;
    in_ch.position       <= position;
    in_ch.start_tile     <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (action == 1'b0)
      page_written[int'(batch) * MAX_BLOCKS + int'(slot)] = 1'b1;
  endtask

  // A paged request never reads an entry that was never written: the entry
  // it would look up is filled first when needed.
  task automatic send_request(input logic [BATCH_W-1:0] batch,
                              input logic [WORD_W-1:0] position,
                              input logic [WORD_W-1:0] start);
    logic [WORD_W-1:0] pos;
    logic [WORD_W-1:0] vblock;
    pos    = (cur.position_modulo != 0) ? position % cur.position_modulo : position;
    vblock = (cur.block_rows != 0) ? pos / cur.block_rows : ALL_ONES;
    if (cur.address_mode == MODE_PAGED && position != ALL_ONES && vblock < MAX_BLOCKS
        && !page_written[int'(batch) * MAX_BLOCKS + int'(vblock)])
      send_word(1'b0, batch, SLOT_W'(vblock), PHYS_W'($urandom), $urandom, $urandom);
    send_word(1'b1, batch, SLOT_W'($urandom), PHYS_W'($urandom), position, start);
  endtask

  initial begin
    cfg_t              s;
    int                r;
    int                items;
    int                span;
    logic [WORD_W-1:0] pos;
    logic [WORD_W-1:0] start;
    logic [BATCH_W-1:0] batch;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_ADDRESS_MODE;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= 1'b0;
    in_ch.batch_index    <= '0;
    in_ch.block_slot     <= '0;
    in_ch.physical_block <= '0;
    in_ch.position       <= '0;
    in_ch.start_tile     <= '0;
    cur = make_settings(MODE_DIRECT, 9'd1, 7'd1, 16'd1, 16'd32, 11'd1, '0, '0);
    tx_idle_pct = 8;
    rx_idle_pct <= 85;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: direct start ids, a skipped position, table extremes.
    send_request(5'd0, '0, '0);
    send_request(5'd31, ALL_ONES - 1, ALL_ONES);
    send_request(5'd0, ALL_ONES, '0);
    send_word(1'b0, 5'd0, 6'd0, '0, '0, '0);
    send_word(1'b0, 5'd31, 6'd63, '1, ALL_ONES, ALL_ONES);

    // Paged with the widest blocks and strides.
    apply_settings(make_settings(MODE_PAGED, 9'd256, 7'd3, 16'hFFFF, 16'd32, 11'd2047,
                                 '0, ALL_ONES));
    send_request(5'd0, '0, '0);
    send_request(5'd31, 32'd2047, '0);
    send_request(5'd31, 32'd2048, '0);
    send_request(5'd7, ALL_ONES, '0);

    // A zero block_rows makes every paged request fault.
    apply_settings(make_settings(MODE_PAGED, 9'd1, 7'd2, 16'd1, 16'd0, 11'd1, '0, '0));
    send_request(5'd3, 32'd5, '0);

    // The spare mode falls back to direct, and the head count saturates.
    apply_settings(make_settings(MODE_SPARE, 9'd511, 7'd127, 16'd0, 16'd32, 11'd0, '0, '0));
    send_request(5'd1, 32'd77, 32'h1234_5678);

    // Contiguous with no heads at all.
    apply_settings(make_settings(MODE_CONTIG, 9'd256, 7'd0, 16'd1, 16'd32, 11'd1, '0,
                                 ALL_ONES));
    send_request(5'd31, ALL_ONES - 1, '0);
    send_request(5'd0, '0, '0);

    // Contiguous with a sliding window.
    apply_settings(make_settings(MODE_CONTIG, 9'd3, 7'd64, 16'd5, 16'd32, 11'd1, 32'd1000,
                                 ALL_ONES));
    send_request(5'd31, ALL_ONES - 1, '0);
    send_request(5'd2, 32'd999, '0);

    // Paged with a window and one position per block.
    apply_settings(make_settings(MODE_PAGED, 9'd7, 7'd4, 16'd9, 16'd1, 11'd5, 32'd100, '0));
    send_request(5'd31, 32'd12345, '0);
    send_request(5'd31, 32'd163, '0);
    send_request(5'd31, 32'd64, '0);

    // Random phases: a fresh setting each, back-pressure changing by thirds.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < PHASES / 3) begin
        tx_idle_pct = 8;
        rx_idle_pct <= 85;
      end else if (ph < 2 * PHASES / 3) begin
        tx_idle_pct = 85;
        rx_idle_pct <= 8;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end

      r = $urandom_range(9);
      s.address_mode = (r < 2) ? MODE_DIRECT : (r < 4) ? MODE_CONTIG :
                       (r < 9) ? MODE_PAGED : MODE_SPARE;
      r = $urandom_range(9);
      s.width_tiles = (r == 0) ? 9'd1 : (r == 1) ? 9'd256 : (r == 2) ? 9'd511 :
                      (r == 3) ? 9'd0 : 9'($urandom_range(256, 1));
      r = $urandom_range(99);
      if (r < 70)      s.head_count = 7'($urandom_range(8, 1));
      else if (r < 80) s.head_count = 7'($urandom_range(63, 9));
      else if (r < 86) s.head_count = 7'd64;
      else if (r < 90) s.head_count = 7'($urandom_range(127, 65));
      else if (r < 95) s.head_count = 7'd0;
      else             s.head_count = 7'd1;
      // The hold-off phase needs results to pile up behind the stalled output.
      if (ph == HOLD_PHASE) s.head_count = 7'd4;
      r = $urandom_range(9);
      s.seq_tiles = (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'd0 :
                    16'($urandom_range(65535));
      r = $urandom_range(99);
      if (r < 55)      s.block_rows = 16'($urandom_range(64, 1));
      else if (r < 70) s.block_rows = 16'($urandom_range(65535, 65));
      else if (r < 80) s.block_rows = 16'hFFFF;
      else if (r < 88) s.block_rows = 16'd0;
      else             s.block_rows = 16'd32;
      r = $urandom_range(9);
      s.block_tiles = (r == 0) ? 11'd2047 : (r == 1) ? 11'd1 : (r == 2) ? 11'd0 :
                      11'($urandom_range(2047));
      r = $urandom_range(99);
      if (r < 50)      s.position_modulo = '0;
      else if (r < 75) s.position_modulo = $urandom_range(5000, 1);
      else if (r < 90) s.position_modulo = $urandom;
      else             s.position_modulo = ALL_ONES;
      r = $urandom_range(9);
      s.batch_stride_tiles = (r == 0) ? '0 : (r == 1) ? ALL_ONES : $urandom;
      items = (s.head_count > 16) ? 6 : 24;
      apply_settings(s);

      for (int i = 0; i < items; i++) begin
        if (ph == HOLD_PHASE && i == 2) -> hold_go;
        batch = $urandom_range(31);
        r = $urandom_range(99);
        if (r < 15) begin
          send_word(1'b0, batch, SLOT_W'($urandom), PHYS_W'($urandom), $urandom, $urandom);
        end else begin
          r = $urandom_range(99);
          if (r < 5)       pos = ALL_ONES;
          else if (r < 10) pos = $urandom;
          else if (r < 13) pos = '0;
          else if (r < 16) pos = ALL_ONES - 1;
          else if (cur.address_mode == MODE_PAGED && $urandom_range(1) == 1) begin
            // Mostly inside the table, with a few blocks just past its end.
            span = 64 * ((cur.block_rows == 0) ? 100 : int'(cur.block_rows)) + 8;
            pos = $urandom_range(span);
          end else begin
            pos = $urandom >> $urandom_range(31);
          end
          r = $urandom_range(9);
          start = (r == 0) ? '0 : (r == 1) ? ALL_ONES : $urandom;
          send_request(batch, pos, start);
        end
      end
    end

    in_ch.valid <= 1'b0;
    drain();
    if (chk_fails == 0 && chk_pending == 0)
      $display("tb_paged_kv_cache_tile_address_generator: clean");
    else
      $display("tb_paged_kv_cache_tile_address_generator: errors");
    $finish;
  end

endmodule
